### rtl/dsfm_pkg.sv
package dsfm_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_GEARBOX_KIND  = 3'd0;
  localparam logic [2:0] CFG_ARCH_2004     = 3'd1;
  localparam logic [2:0] CFG_INVALID_STATE = 3'd2;
  localparam logic [2:0] CFG_FRM_DELAY     = 3'd3;
  localparam logic [2:0] CFG_FAULT_DELAY   = 3'd4;
  localparam logic [2:0] CFG_INHIBIT_MASK  = 3'd5;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Gearbox kinds; only AUTO and AMT run checks, any other code runs none.
  localparam logic [1:0] GBX_AUTO  = 2'd0;
  localparam logic [1:0] GBX_AMT   = 2'd1;
  localparam logic [1:0] GBX_OTHER = 2'd2;

  // Bits of the inhibit mask.
  localparam int unsigned INH_FRAME  = 0;
  localparam int unsigned INH_2010   = 1;
  localparam int unsigned INH_START  = 2;
  localparam int unsigned INH_SAFETY = 3;

  // Turn-on delay: threshold is (delay + DlyOffset) >> DlyShift.
  localparam int unsigned DelayW     = 16;
  localparam int unsigned CountW     = 15;
  localparam int unsigned DlyOffset  = 6;
  localparam int unsigned DlyShift   = 2;

  typedef struct packed {
    logic [7:0] drivetrain_state;
    logic       frame_invalid_active;
    logic       park_neutral_ext;
    logic       park_neutral_sensor;
    logic       auto_state_out_of_range;
    logic       start_authorized;
    logic       amt_drive_engaged_ext;
    logic       amt_start_inhibit;
    logic       amt_state_out_of_range;
  } in_item_t;

  typedef struct packed {
    logic frame_fault_raw;
    logic frame_fault_confirmed;
    logic drivetrain_fault_raw;
    logic drivetrain_fault_confirmed;
    logic safety_inhibit_request;
  } out_item_t;

  // Raw conditions handed from the check logic to the delay counters.
  typedef struct packed {
    logic frame_raw;
    logic merged_raw;
  } check_res_t;

endpackage

### rtl/dsfm_if.sv
interface dsfm_in_if;
  import dsfm_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface dsfm_out_if;
  import dsfm_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/drivetrain_safety_fault_monitor_top.sv
// Drivetrain safety fault monitor.
//
// Each item on the input channel is one monitoring tick of sampled drivetrain
// signals, and each tick yields exactly one result item on the output channel.
// Both channels use a valid/ready handshake; an item moves on a rising edge
// where valid and ready are both high.
// An accepted item lands in an input register; the checks, the held check
// results and the two turn-on-delay counters are evaluated from it
// combinationally and the result is written to the output register, which
// then presents it as valid. One item per cycle is sustained while the
// receiver does not stall.
// When the receiver stalls, the output register holds its result and the
// input register still takes one more item, so ready falls only when both
// are full. The configuration port is a plain write port and must only be
// written while no item is in flight.
// Reset clears both registers' valid flags, the held check results and the
// delay counters, and loads the configuration with its reset values (gearbox
// kind "other", so no gearbox check runs until configured).
module drivetrain_safety_fault_monitor_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dsfm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [dsfm_pkg::CfgDataW-1:0]   cfg_wdata_i,
  dsfm_in_if.sink                         in_if,
  dsfm_out_if.source                      out_if
);
  import dsfm_pkg::*;

  // Configuration registers.
  logic [1:0]        gearbox_kind_q;
  logic              arch_2004_q;
  logic [7:0]        invalid_state_code_q;
  logic [DelayW-1:0] frm_delay_q;
  logic [DelayW-1:0] fault_delay_q;
  logic [3:0]        inhibit_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gearbox_kind_q       <= GBX_OTHER;
      arch_2004_q          <= 1'b0;
      invalid_state_code_q <= '0;
      frm_delay_q          <= '0;
      fault_delay_q        <= '0;
      inhibit_mask_q       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GEARBOX_KIND:  gearbox_kind_q       <= cfg_wdata_i[1:0];
        CFG_ARCH_2004:     arch_2004_q          <= cfg_wdata_i[0];
        CFG_INVALID_STATE: invalid_state_code_q <= cfg_wdata_i[7:0];
        CFG_FRM_DELAY:     frm_delay_q          <= cfg_wdata_i[DelayW-1:0];
        CFG_FAULT_DELAY:   fault_delay_q        <= cfg_wdata_i[DelayW-1:0];
        CFG_INHIBIT_MASK:  inhibit_mask_q       <= cfg_wdata_i[3:0];
        default: begin
          // Writes to unused indexes are dropped.
        end
      endcase
    end
  end

  // Input register and output register with their valid flags.
  in_item_t  in_q;
  logic      in_vld_q;
  out_item_t out_q, out_d;
  logic      out_vld_q;
  logic      adv;
  logic      in_acc;

  // The item in the input register advances whenever the output slot is free
  // or is being emptied in this cycle.
  assign adv          = in_vld_q && (!out_vld_q || out_if.ready);
  assign in_if.ready  = !in_vld_q || adv;
  assign in_acc       = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_if.payload;
    end
  end

  check_res_t chk;
  logic       frm_conf;
  logic       fault_conf;

  dsfm_check u_check (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .adv_i                (adv),
    .item_i               (in_q),
    .gearbox_kind_i       (gearbox_kind_q),
    .arch_2004_i          (arch_2004_q),
    .invalid_state_code_i (invalid_state_code_q),
    .inhibit_mask_i       (inhibit_mask_q),
    .res_o                (chk)
  );

  dsfm_tod u_frm_tod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .cond_i  (chk.frame_raw),
    .delay_i (frm_delay_q),
    .conf_o  (frm_conf)
  );

  dsfm_tod u_fault_tod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .cond_i  (chk.merged_raw),
    .delay_i (fault_delay_q),
    .conf_o  (fault_conf)
  );

  always_comb begin
    out_d.frame_fault_raw            = chk.frame_raw;
    out_d.frame_fault_confirmed      = frm_conf && !inhibit_mask_q[INH_FRAME];
    out_d.drivetrain_fault_raw       = chk.merged_raw;
    out_d.drivetrain_fault_confirmed = fault_conf;
    out_d.safety_inhibit_request     = fault_conf && !inhibit_mask_q[INH_SAFETY];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_if.valid   = out_vld_q;
  assign out_if.payload = out_q;

endmodule

### rtl/dsfm_check.sv
module dsfm_check (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  dsfm_pkg::in_item_t    item_i,
  input  logic [1:0]            gearbox_kind_i,
  input  logic                  arch_2004_i,
  input  logic [7:0]            invalid_state_code_i,
  input  logic [3:0]            inhibit_mask_i,
  output dsfm_pkg::check_res_t  res_o
);
  import dsfm_pkg::*;

  logic held_2010_q, held_2010_d;
  logic held_start_q, held_start_d;

  // A check that does not run for this gearbox kind or architecture keeps its last result.
  always_comb begin
    held_2010_d  = held_2010_q;
    held_start_d = held_start_q;
    case (gearbox_kind_i)
      GBX_AUTO: begin
        if (!arch_2004_i) begin
          held_2010_d = (item_i.park_neutral_ext == item_i.park_neutral_sensor) &&
                        !item_i.auto_state_out_of_range;
        end
        held_start_d = item_i.start_authorized && !item_i.park_neutral_sensor;
      end
      GBX_AMT: begin
        if (!arch_2004_i) begin
          held_2010_d = (item_i.amt_drive_engaged_ext == item_i.amt_start_inhibit) &&
                        !item_i.amt_state_out_of_range;
        end
        held_start_d = item_i.start_authorized && !item_i.amt_start_inhibit;
      end
      default: begin
        held_2010_d  = held_2010_q;
        held_start_d = held_start_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_2010_q  <= 1'b0;
      held_start_q <= 1'b0;
    end else if (adv_i) begin
      held_2010_q  <= held_2010_d;
      held_start_q <= held_start_d;
    end
  end

  assign res_o.frame_raw  = (item_i.drivetrain_state != invalid_state_code_i) &&
                            item_i.frame_invalid_active;
  assign res_o.merged_raw = (held_2010_d && !inhibit_mask_i[INH_2010]) ||
                            (held_start_d && !inhibit_mask_i[INH_START]);

endmodule

### rtl/dsfm_tod.sv
module dsfm_tod (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          cond_i,
  input  logic [dsfm_pkg::DelayW-1:0]   delay_i,
  output logic                          conf_o
);
  import dsfm_pkg::*;

  logic [DelayW:0]   sum;
  logic [CountW-1:0] thr;
  logic [CountW-1:0] sat;
  logic [CountW-1:0] count_q, count_d;

  // The sum never wraps, and the threshold is at least one.
  assign sum = {1'b0, delay_i} + (DelayW+1)'(DlyOffset);
  assign thr = sum[DelayW:DlyShift];
  assign sat = (count_q > thr) ? thr : count_q;

  always_comb begin
    if (cond_i) begin
      count_d = sat + CountW'(1);
    end else begin
      count_d = '0;
    end
  end

  assign conf_o = (count_d >= thr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (adv_i) begin
      count_q <= count_d;
    end
  end

endmodule
